// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SWS_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sws assertion failed");

// Checked on every edge, reset included.
`define SWS_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("sws assertion failed");

`endif

// ===== hw/rtl/sws_pkg.sv =====
// ---------------------------------------------------------------------------
// sws_pkg
// Types and constants of the supply window supervisor.
// ---------------------------------------------------------------------------
package sws_pkg;

	localparam int WIN_W      = 10;
	localparam int IVL_W      = 16;
	localparam int LIM_W      = 8;
	localparam int CNT_W      = 8;
	localparam int ELAPSED_W  = 17;
	localparam int REPORT_W   = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIN_W-1:0] WINDOW_LOW_RST    = 10'd660;
	localparam logic [WIN_W-1:0] WINDOW_HIGH_RST   = 10'd840;
	localparam logic [IVL_W-1:0] FAST_INTERVAL_RST = 16'd100;
	localparam logic [IVL_W-1:0] SLOW_INTERVAL_RST = 16'd1000;
	localparam logic [LIM_W-1:0] BLINK_LIMIT_RST   = 8'd20;
	localparam logic [LIM_W-1:0] GOOD_LIMIT_RST    = 8'd10;

	localparam logic [7:0]           VOLT_SCALE  = 8'd173;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;
	localparam logic [CNT_W-1:0]     CNT_MAX     = 8'hFF;

	// Mode codes as seen on the result port
	localparam logic [1:0] MODE_CODE_INIT    = 2'd0;
	localparam logic [1:0] MODE_CODE_QUALIFY = 2'd1;
	localparam logic [1:0] MODE_CODE_RUN     = 2'd2;
	localparam logic [1:0] MODE_CODE_FAULT   = 2'd3;

	typedef enum logic [3:0] {
		MODE_INIT    = 4'b0001,
		MODE_QUALIFY = 4'b0010,
		MODE_RUN     = 4'b0100,
		MODE_FAULT   = 4'b1000
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LOW    = 3'd0,
		CFG_WINDOW_HIGH   = 3'd1,
		CFG_FAST_INTERVAL = 3'd2,
		CFG_SLOW_INTERVAL = 3'd3,
		CFG_BLINK_LIMIT   = 3'd4,
		CFG_GOOD_LIMIT    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_low;
		logic [WIN_W-1:0] window_high;
		logic [IVL_W-1:0] fast_interval;
		logic [IVL_W-1:0] slow_interval;
		logic [LIM_W-1:0] blink_limit;
		logic [LIM_W-1:0] good_limit;
	} sws_cfg_t;

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		case (m)
			MODE_INIT:    c = MODE_CODE_INIT;
			MODE_QUALIFY: c = MODE_CODE_QUALIFY;
			MODE_RUN:     c = MODE_CODE_RUN;
			default:      c = MODE_CODE_FAULT;
		endcase
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 8'd1;
	endfunction

endpackage

// ===== hw/rtl/sws_cfg.sv =====
// ---------------------------------------------------------------------------
// sws_cfg
// Configuration register file; writes take effect at the next edge.
// ---------------------------------------------------------------------------
module sws_cfg
	import sws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output sws_cfg_t              cfg
);

	sws_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low    <= WINDOW_LOW_RST;
			cfg_q.window_high   <= WINDOW_HIGH_RST;
			cfg_q.fast_interval <= FAST_INTERVAL_RST;
			cfg_q.slow_interval <= SLOW_INTERVAL_RST;
			cfg_q.blink_limit   <= BLINK_LIMIT_RST;
			cfg_q.good_limit    <= GOOD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LOW:    cfg_q.window_low    <= cfg_wdata[WIN_W-1:0];
				CFG_WINDOW_HIGH:   cfg_q.window_high   <= cfg_wdata[WIN_W-1:0];
				CFG_FAST_INTERVAL: cfg_q.fast_interval <= cfg_wdata[IVL_W-1:0];
				CFG_SLOW_INTERVAL: cfg_q.slow_interval <= cfg_wdata[IVL_W-1:0];
				CFG_BLINK_LIMIT:   cfg_q.blink_limit   <= cfg_wdata[LIM_W-1:0];
				CFG_GOOD_LIMIT:    cfg_q.good_limit    <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/supply_window_supervisor_unit.sv =====
// ---------------------------------------------------------------------------
// supply_window_supervisor_unit: supply window supervisor, one tick per item
// Result: registered in the cycle after the sample item is accepted.
// Throughput: one item per cycle while results are taken; the result register refills as it drains.
// Reset: async, init mode, counters and drives cleared, config at defaults.
// ---------------------------------------------------------------------------
module supply_window_supervisor_unit
	import sws_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	// sample items
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	// result items
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   led_on,
	output logic                   switch_on,
	output logic [1:0]             mode_now,
	output logic                   report_valid,
	output logic [REPORT_W-1:0]    voltage_report
);

	localparam int CMP_W  = (SAMPLE_BITS > WIN_W) ? SAMPLE_BITS : WIN_W;
	localparam int PROD_W = SAMPLE_BITS + 8;

	sws_cfg_t cfg;

	sws_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// supervisor state
	mode_t                mode_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 phase_q;
	logic                 led_q;
	logic                 switch_q;
	logic [CNT_W-1:0]     blink_q;
	logic [CNT_W-1:0]     good_q;

	// result register
	logic                 result_valid_q;
	logic [1:0]           mode_now_q;
	logic                 report_valid_q;
	logic [REPORT_W-1:0]  voltage_report_q;

	mode_t                mode_d;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [ELAPSED_W-1:0] elapsed_d;
	logic                 phase_d;
	logic                 led_d;
	logic                 switch_d;
	logic [CNT_W-1:0]     blink_d;
	logic [CNT_W-1:0]     good_d;
	logic                 report_d;
	logic                 in_win;
	logic                 fast_hit;
	logic                 slow_hit;
	logic [PROD_W-1:0]    prod;
	logic                 accept;

	assign sample_ready = !result_valid_q || result_ready;
	assign accept       = sample_valid && sample_ready;

	assign prod = PROD_W'(adc_sample) * PROD_W'(VOLT_SCALE);

	always_comb begin
		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 17'd1;
		in_win      = (CMP_W'(adc_sample) >= CMP_W'(cfg.window_low)) &&
		              (CMP_W'(adc_sample) <= CMP_W'(cfg.window_high));
		fast_hit    = elapsed_inc > ELAPSED_W'(cfg.fast_interval);
		slow_hit    = elapsed_inc > ELAPSED_W'(cfg.slow_interval);

		mode_d    = mode_q;
		elapsed_d = elapsed_inc;
		phase_d   = phase_q;
		led_d     = led_q;
		switch_d  = switch_q;
		blink_d   = blink_q;
		good_d    = good_q;
		report_d  = 1'b0;

		case (mode_q)
			MODE_INIT: begin
				switch_d = 1'b0;
				led_d    = 1'b1;
				blink_d  = '0;
				mode_d   = MODE_QUALIFY;
			end
			MODE_QUALIFY: begin
				if (fast_hit) begin
					elapsed_d = '0;
					blink_d   = sat_inc(blink_q);
					phase_d   = !phase_q;
					led_d     = !phase_q;
					good_d    = in_win ? sat_inc(good_q) : '0;
				end
				// limit check runs every qualify tick, on the updated counts
				if (blink_d > cfg.blink_limit && good_d > cfg.good_limit)
					mode_d = MODE_RUN;
			end
			MODE_RUN: begin
				if (slow_hit) begin
					elapsed_d = '0;
					phase_d   = !phase_q;
					led_d     = !phase_q;
					report_d  = 1'b1;
					switch_d  = in_win;
					if (!in_win)
						mode_d = MODE_FAULT;
				end
			end
			default: begin
				if (fast_hit) begin
					elapsed_d = '0;
					phase_d   = !phase_q;
					led_d     = !phase_q;
					report_d  = 1'b1;
					if (in_win)
						mode_d = MODE_INIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INIT;
			elapsed_q <= '0;
			phase_q   <= 1'b0;
			led_q     <= 1'b0;
			switch_q  <= 1'b0;
			blink_q   <= '0;
			good_q    <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
			phase_q   <= phase_d;
			led_q     <= led_d;
			switch_q  <= switch_d;
			blink_q   <= blink_d;
			good_q    <= good_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_now_q       <= mode_code(mode_d);
			report_valid_q   <= report_d;
			voltage_report_q <= report_d ? REPORT_W'(prod) : '0;
		end
	end

	assign result_valid   = result_valid_q;
	assign led_on         = led_q;
	assign switch_on      = switch_q;
	assign mode_now       = mode_now_q;
	assign report_valid   = report_valid_q;
	assign voltage_report = voltage_report_q;

endmodule

// ===== hw/rtl/sws_checker.sv =====
// ---------------------------------------------------------------------------
// sws_checker
// Port-level checks of the supervisor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sws_checker
	import sws_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_ready,
	input logic                switch_on,
	input logic [1:0]          mode_now,
	input logic                report_valid,
	input logic [REPORT_W-1:0] voltage_report
);

	// no report, no voltage
	`SWS_ASSERT(a_no_report_zero, clk, arst_n, (result_valid && !report_valid) |-> (voltage_report == '0))

	// init after a tick is only reached from fault on a reporting event
	`SWS_ASSERT(a_init_from_fault, clk, arst_n, (result_valid && mode_now == MODE_CODE_INIT) |-> report_valid)

	// switch is open whenever qualify or fault holds
	`SWS_ASSERT(a_switch_open, clk, arst_n, (result_valid && (mode_now == MODE_CODE_QUALIFY || mode_now == MODE_CODE_FAULT)) |-> !switch_on)

	// a stalled result holds
	`SWS_ASSERT(a_stall_hold, clk, arst_n, (result_valid && !result_ready) |=> (result_valid && $stable(voltage_report) && $stable(mode_now)))

	// nothing offered on the edge after one seen in reset
	`SWS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !result_valid)

endmodule

bind supply_window_supervisor_unit sws_checker u_sws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.switch_on      (switch_on),
	.mode_now       (mode_now),
	.report_valid   (report_valid),
	.voltage_report (voltage_report)
);

// ===== sim/tb_supply_window_supervisor_unit.sv =====
// ---------------------------------------------------------------------------
// tb_supply_window_supervisor_unit
// Self-checking bench for the supply window supervisor. Every accepted sample
// item runs through a local model of the mode machine, and the result item is
// compared field by field. Covers power-up defaults, a directed mode walk,
// counter saturation, output stalls and random traffic under idle and stall mixes.
// ---------------------------------------------------------------------------
module tb_supply_window_supervisor_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import sws_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_SCALE = 173;
	localparam int SHOW_MAX     = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [WIN_W-1:0]     CODE_MAX    = 10'h3FF;

	typedef struct packed {
		logic                led;
		logic                sw;
		logic [1:0]          mode;
		logic                rpt;
		logic [REPORT_W-1:0] volts;
	} tick_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic [WIN_W-1:0]      adc_sample = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic                  led_on;
	logic                  switch_on;
	logic [1:0]            mode_now;
	logic                  report_valid;
	logic [REPORT_W-1:0]   voltage_report;

	// supervisor model state
	sws_cfg_t cfg_now = '{WINDOW_LOW_RST, WINDOW_HIGH_RST, FAST_INTERVAL_RST,
		SLOW_INTERVAL_RST, BLINK_LIMIT_RST, GOOD_LIMIT_RST};
	logic [1:0]           sup_mode = MODE_CODE_INIT;
	logic [ELAPSED_W-1:0] tick_count = '0;
	logic                 blink_phase_q = 1'b0;
	logic                 led_q = 1'b0;
	logic                 sw_q = 1'b0;
	logic [CNT_W-1:0]     blink_cnt = '0;
	logic [CNT_W-1:0]     good_cnt = '0;

	tick_out_t expected_ticks[$];
	int        mismatches = 0;
	int        cycles = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	int        hold_off = 0;
	int        bad_run = 0;

	supply_window_supervisor_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.adc_sample     (adc_sample),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.led_on         (led_on),
		.switch_on      (switch_on),
		.mode_now       (mode_now),
		.report_valid   (report_valid),
		.voltage_report (voltage_report)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic sample_in_win(logic [WIN_W-1:0] s);
		return s >= cfg_now.window_low && s <= cfg_now.window_high;
	endfunction

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void toggle_blink();
		blink_phase_q = ~blink_phase_q;
		led_q = blink_phase_q;
	endfunction

	function automatic tick_out_t advance_tick(logic [WIN_W-1:0] s);
		tick_out_t r;
		r = '0;
		if (tick_count != ELAPSED_MAX)
			tick_count = tick_count + 1'b1;
		case (sup_mode)
			MODE_CODE_INIT: begin
				// blink_phase and good_cnt survive init
				sw_q = 1'b0;
				led_q = 1'b1;
				blink_cnt = '0;
				sup_mode = MODE_CODE_QUALIFY;
			end
			MODE_CODE_QUALIFY: begin
				if (tick_count > cfg_now.fast_interval) begin
					tick_count = '0;
					blink_cnt = bump(blink_cnt);
					toggle_blink();
					good_cnt = sample_in_win(s) ? bump(good_cnt) : '0;
				end
				// checked every tick, not only on blink ticks
				if (blink_cnt > cfg_now.blink_limit && good_cnt > cfg_now.good_limit)
					sup_mode = MODE_CODE_RUN;
			end
			MODE_CODE_RUN: begin
				if (tick_count > cfg_now.slow_interval) begin
					tick_count = '0;
					toggle_blink();
					r.rpt = 1'b1;
					if (sample_in_win(s)) begin
						sw_q = 1'b1;
					end else begin
						sw_q = 1'b0;
						sup_mode = MODE_CODE_FAULT;
					end
				end
			end
			default: begin
				if (tick_count > cfg_now.fast_interval) begin
					tick_count = '0;
					toggle_blink();
					r.rpt = 1'b1;
					if (sample_in_win(s))
						sup_mode = MODE_CODE_INIT;
				end
			end
		endcase
		r.led = led_q;
		r.sw = sw_q;
		r.mode = sup_mode;
		if (r.rpt)
			r.volts = REPORT_W'(s) * REPORT_W'(REPORT_SCALE);
		return r;
	endfunction

	// mostly in-window samples, with bursts outside to push run into fault
	function automatic logic [WIN_W-1:0] pick_sample();
		logic [WIN_W-1:0] lo;
		logic [WIN_W-1:0] hi;
		lo = cfg_now.window_low;
		hi = cfg_now.window_high;
		if (bad_run == 0 && $urandom_range(99) < 4)
			bad_run = $urandom_range(12, 1);
		if (lo > hi || $urandom_range(99) < 8)
			return WIN_W'($urandom);
		if (bad_run > 0) begin
			bad_run--;
			if (lo != 0 && (hi == CODE_MAX || $urandom_range(1) == 1))
				return WIN_W'($urandom_range(lo - 1, 0));
			if (hi != CODE_MAX)
				return WIN_W'($urandom_range(CODE_MAX, hi + 1));
		end
		return WIN_W'($urandom_range(hi, lo));
	endfunction

	function automatic sws_cfg_t random_config();
		sws_cfg_t c;
		int lo;
		int hi;
		lo = ($urandom_range(3) == 0) ? 0 : $urandom_range(900);
		hi = lo + $urandom_range(400, 30);
		if (hi > CODE_MAX)
			hi = CODE_MAX;
		if ($urandom_range(9) == 0)
			hi = $urandom_range(CODE_MAX);
		c.window_low = WIN_W'(lo);
		c.window_high = WIN_W'(hi);
		c.fast_interval = ($urandom_range(9) == 0) ? IVL_W'($urandom_range(60))
			: IVL_W'($urandom_range(4));
		c.slow_interval = ($urandom_range(9) == 0) ? IVL_W'($urandom_range(60))
			: IVL_W'($urandom_range(8));
		c.blink_limit = ($urandom_range(19) == 0) ? LIM_W'($urandom)
			: LIM_W'($urandom_range(6));
		c.good_limit = LIM_W'($urandom_range(4));
		return c;
	endfunction

	// prediction and checking, both sampled at the rising edge
	always @(posedge clk) begin
		tick_out_t want;
		cycles <= cycles + 1;
		if (arst_n && sample_valid && sample_ready)
			expected_ticks.push_back(advance_tick(adc_sample));
		if (arst_n && result_valid && result_ready) begin
			if (expected_ticks.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("result with no item pending: led=%0b sw=%0b mode=%0d rpt=%0b v=%0d",
						led_on, switch_on, mode_now, report_valid, voltage_report);
			end else begin
				want = expected_ticks.pop_front();
				if (led_on !== want.led || switch_on !== want.sw || mode_now !== want.mode
						|| report_valid !== want.rpt || voltage_report !== want.volts) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("mismatch exp led=%0b sw=%0b mode=%0d rpt=%0b v=%0d, got led=%0b sw=%0b mode=%0d rpt=%0b v=%0d",
							want.led, want.sw, want.mode, want.rpt, want.volts,
							led_on, switch_on, mode_now, report_valid, voltage_report);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off = hold_off - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("[supply_window_supervisor_unit] ERROR");
		$finish;
	end

	// leaves valid high after acceptance; the next call or drain() takes it over
	task automatic send_sample(input logic [WIN_W-1:0] s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// upper data bits are junk the registers must drop; spare indexes must be ignored
	task automatic load_config(input sws_cfg_t c);
		write_reg(CFG_WINDOW_LOW, {6'($urandom), c.window_low});
		write_reg(CFG_WINDOW_HIGH, {6'($urandom), c.window_high});
		write_reg(CFG_FAST_INTERVAL, c.fast_interval);
		write_reg(CFG_SLOW_INTERVAL, c.slow_interval);
		write_reg(CFG_BLINK_LIMIT, {8'($urandom), c.blink_limit});
		write_reg(CFG_GOOD_LIMIT, {8'($urandom), c.good_limit});
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_SPARE_B, 16'($urandom));
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	task automatic test_power_up_defaults();
		send_sample(10'd700);
		send_sample(10'd0);
		send_sample(CODE_MAX);
		send_sample(WINDOW_LOW_RST);
		send_sample(WINDOW_HIGH_RST);
		repeat (7) send_sample(WIN_W'($urandom_range(WINDOW_HIGH_RST, WINDOW_LOW_RST)));
		drain();
	endtask

	task automatic test_mode_walk();
		load_config(sws_cfg_t'{10'd0, CODE_MAX, 16'd0, 16'd0, 8'd0, 8'd0});
		send_sample(CODE_MAX);      // qualify -> run
		send_sample(10'd0);
		send_sample(CODE_MAX);      // largest report
		send_sample(10'd512);
		drain();
		load_config(sws_cfg_t'{10'd100, 10'd200, 16'd0, 16'd0, 8'd0, 8'd0});
		send_sample(10'd0);         // run -> fault
		send_sample(CODE_MAX);
		send_sample(10'd150);       // fault -> init
		send_sample(10'd99);
		send_sample(10'd201);
		send_sample(10'd100);
		send_sample(10'd200);
		drain();
		// inverted window: nothing is in range
		load_config(sws_cfg_t'{10'd600, 10'd500, 16'd0, 16'd0, 8'd0, 8'd0});
		send_sample(10'd550);
		send_sample(10'd600);
		send_sample(10'd500);
		drain();
		load_config(sws_cfg_t'{10'd300, 10'd300, 16'd1, 16'd0, 8'd0, 8'd0});
		send_sample(10'd300);
		send_sample(10'd299);
		send_sample(10'd300);
		send_sample(10'd301);
		send_sample(10'd300);
		send_sample(10'd300);
		drain();
	endtask

	task automatic test_counter_saturation();
		load_config(sws_cfg_t'{10'd0, 10'd511, 16'd0, 16'd0, 8'hFF, 8'hFF});
		while (sup_mode != MODE_CODE_QUALIFY) begin
			send_sample(sup_mode == MODE_CODE_RUN ? CODE_MAX : 10'd0);
			drain();
		end
		load_config(sws_cfg_t'{10'd0, CODE_MAX, 16'd0, 16'hFFFF, 8'hFF, 8'hFF});
		repeat (300) send_sample(WIN_W'($urandom));
		drain();
		// both counts pinned at 255: leaves qualify on a tick without a blink
		load_config(sws_cfg_t'{10'd0, CODE_MAX, 16'hFFFF, 16'hFFFF, 8'hFE, 8'hFE});
		repeat (6) send_sample(WIN_W'($urandom));
		drain();
	endtask

	task automatic test_output_backpressure();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		load_config(random_config());
		hold_off = 200;
		repeat (60) send_sample(pick_sample());
		drain();
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 75 == 0) begin
				drain();
				load_config(random_config());
			end
			send_sample(pick_sample());
		end
		drain();
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0, 130);
		run_random_phase(86, 0, 130);
		run_random_phase(0, 86, 130);
		run_random_phase(35, 35, 130);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up_defaults();
		test_mode_walk();
		test_counter_saturation();
		test_output_backpressure();
		test_random_traffic();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("[supply_window_supervisor_unit] OK");
		else
			$display("[supply_window_supervisor_unit] ERROR");
		$finish;
	end

endmodule
